// ===== sv/mctm_pkg.sv =====
`default_nettype none

package mctm_pkg;

    localparam int CLOCKS_PER_BEAT_DEF = 24;

    localparam int RATE_W     = 18;
    localparam int TIME_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int CHAN_W     = 4;
    localparam int KIND_W     = 2;
    localparam int WORD_W     = 32;
    localparam int DIV_CNT_W  = 5;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 96;

    localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(48000);
    localparam logic [WORD_W-1:0] TEMPO_RESET = WORD_W'(30720);
    localparam logic [WORD_W-1:0] TEMPO_SAT   = '1;

    localparam logic [BYTE_W-1:0] SB_SYS_MASK  = 8'hF0;
    localparam logic [BYTE_W-1:0] SB_CHAN_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] SB_CLOCK     = 8'hF8;
    localparam logic [BYTE_W-1:0] SB_START     = 8'hFA;
    localparam logic [BYTE_W-1:0] SB_STOP      = 8'hFC;

    localparam logic [KIND_W-1:0] KIND_TEMPO = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SYS   = 2'd2;

    localparam logic MODE_EVENT  = 1'b0;
    localparam logic MODE_PERIOD = 1'b1;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== sv/mctm_div.sv =====
`default_nettype none

module mctm_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mctm_pkg::div_req_t req,
    output mctm_pkg::div_rsp_t      rsp
);
    import mctm_pkg::*;

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(WORD_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [WORD_W-1:0]    rem_reg;
    logic [WORD_W-1:0]    quo_reg;
    logic [WORD_W-1:0]    den_reg;

    logic [WORD_W:0]   rem_sh;
    logic [WORD_W+1:0] diff;
    logic              fits;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[WORD_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, den_reg};
        fits   = ~diff[WORD_W+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !req.start && busy_reg && (cnt_reg == CNT_LAST);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // one restoring step per cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
            quo_reg <= {quo_reg[WORD_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== sv/midi_clock_tempo_meter_unit.sv =====
// MIDI clock tempo meter; CLOCKS_PER_BEAT (default CLOCKS_PER_BEAT_DEF) sets the beat.
// Input stream: s_tuser carries the mode (0 MIDI status event, 1 end of
// audio period); s_tdata carries status byte, frame time and period length.
// Output stream: m_tuser carries the report kind (tempo, channel, system);
// m_tdata carries type, channel, event time, tempo (Q.8 BPM), beat sum and
// the zero-sum flag. The sample rate is written through cfg_we/cfg_wdata.
// One word is taken at a time; s_tready is high only while idle.
// Period marks, Start and Stop are handled while idle; a clock that does
// not close a beat passes the clock state back to idle. Channel and system
// reports pass to the put state, which loads the output register once free.
// A clock that closes a beat passes an accumulate step, then the 32-step
// restoring divider: 60 * 256 * sample_rate / sum, one quotient bit per
// cycle; a zero sum skips it and saturates the tempo. Beat intervals are
// accumulated as they arrive, so no pass over the stored intervals is needed
// when the beat closes. Reset clears the sequencer, the beat counter and the
// reference time, sets the tempo to 120 BPM and the sample rate to 48000.
// A report waits in the output register until m_tready; while it waits the
// block still takes words, and waits on the output only for a second report.
`default_nettype none

module midi_clock_tempo_meter_unit #(
    parameter int CLOCKS_PER_BEAT = mctm_pkg::CLOCKS_PER_BEAT_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // status_byte[7:0], frame_time[23:8], period_frames[39:24]
    input  wire logic [mctm_pkg::IN_TDATA_W-1:0]    s_tdata,
    // mode[0]
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // message_type[7:0], channel[11:8], event_time[27:12], tempo_q8[59:28],
    // interval_sum[91:60], zero_sum[92], zero fill[95:93]
    output logic [mctm_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // report_kind[1:0]
    output logic [mctm_pkg::KIND_W-1:0]             m_tuser,
    input  wire logic                               cfg_we,
    input  wire logic [mctm_pkg::RATE_W-1:0]        cfg_wdata
);
    import mctm_pkg::*;

    localparam int SLOT_W = $clog2(CLOCKS_PER_BEAT + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CLOCKS_PER_BEAT - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CLK  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_PUT  = 2'd3;

    logic [1:0]          state_reg;
    logic [RATE_W-1:0]   sample_rate_reg;
    logic [TIME_W-1:0]   last_clock_reg;
    logic                clock_seen_reg;
    logic [WORD_W-1:0]   carry_reg;
    logic                running_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [WORD_W-1:0]   acc_reg;
    logic [WORD_W-1:0]   tempo_held_reg;
    logic                m_tvalid_reg;

    logic [TIME_W-1:0]   t_reg;
    logic [WORD_W-1:0]   iv_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [BYTE_W-1:0]   type_reg;
    logic [CHAN_W-1:0]   chan_reg;
    logic [WORD_W-1:0]   sum_reg;
    logic                zero_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [KIND_W-1:0]   m_tuser_reg;

    logic                in_take;
    logic                in_mode;
    logic [BYTE_W-1:0]   in_sb;
    logic [TIME_W-1:0]   in_t;
    logic [TIME_W-1:0]   in_pf;
    logic                in_sys;
    logic [WORD_W-1:0]   iv_calc;
    logic [WORD_W-1:0]   sum_calc;
    logic                sum_zero;
    logic                last_slot;
    logic                out_load;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    always_comb
    begin
        in_take   = s_tvalid && s_tready;
        in_mode   = s_tuser;
        in_sb     = s_tdata[7:0];
        in_t      = s_tdata[23:8];
        in_pf     = s_tdata[39:24];
        in_sys    = (in_sb & SB_SYS_MASK) == SB_SYS_MASK;
        iv_calc   = {16'd0, in_t} - {16'd0, last_clock_reg}
                    + (clock_seen_reg ? '0 : carry_reg);
        sum_calc  = acc_reg + iv_reg;
        sum_zero  = sum_calc == '0;
        last_slot = slot_reg == LAST_SLOT;
        out_load  = (state_reg == ST_PUT) && (!m_tvalid_reg || m_tready);

        div_req.start    = (state_reg == ST_CLK) && last_slot && !sum_zero;
        div_req.dividend = {sample_rate_reg, 14'd0} - {4'd0, sample_rate_reg, 10'd0};
        div_req.divisor  = sum_calc;
    end

    mctm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            sample_rate_reg <= RATE_RESET;
            last_clock_reg  <= '0;
            clock_seen_reg  <= 1'b0;
            carry_reg       <= '0;
            running_reg     <= 1'b0;
            slot_reg        <= '0;
            acc_reg         <= '0;
            tempo_held_reg  <= TEMPO_RESET;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                sample_rate_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        if (in_mode == MODE_PERIOD)
                        begin
                            if (running_reg)
                            begin
                                carry_reg <= clock_seen_reg ? {16'd0, in_pf}
                                                            : carry_reg + {16'd0, in_pf};
                            end
                            clock_seen_reg <= 1'b0;
                        end
                        else if (!in_sys)
                        begin
                            state_reg <= ST_PUT;
                        end
                        else
                        begin
                            unique case (in_sb)
                                SB_CLOCK:
                                begin
                                    clock_seen_reg <= 1'b1;
                                    last_clock_reg <= in_t;
                                    state_reg      <= ST_CLK;
                                end
                                SB_START:
                                begin
                                    running_reg    <= 1'b1;
                                    clock_seen_reg <= 1'b1;
                                    slot_reg       <= '0;
                                    acc_reg        <= '0;
                                    last_clock_reg <= in_t;
                                end
                                SB_STOP:
                                begin
                                    running_reg <= 1'b0;
                                end
                                default:
                                begin
                                    state_reg <= ST_PUT;
                                end
                            endcase
                        end
                    end
                end
                ST_CLK:
                begin
                    if (last_slot)
                    begin
                        slot_reg <= '0;
                        acc_reg  <= '0;
                        if (sum_zero)
                        begin
                            tempo_held_reg <= TEMPO_SAT;
                            state_reg      <= ST_PUT;
                        end
                        else
                        begin
                            state_reg <= ST_DIV;
                        end
                    end
                    else
                    begin
                        acc_reg   <= sum_calc;
                        slot_reg  <= slot_reg + 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        tempo_held_reg <= div_rsp.quotient;
                        state_reg      <= ST_PUT;
                    end
                end
                ST_PUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && in_take && (in_mode == MODE_EVENT))
        begin
            t_reg    <= in_t;
            iv_reg   <= iv_calc;
            sum_reg  <= '0;
            zero_reg <= 1'b0;
            if (!in_sys)
            begin
                kind_reg <= KIND_CHAN;
                type_reg <= in_sb & SB_SYS_MASK;
                chan_reg <= CHAN_W'(in_sb & SB_CHAN_MASK);
            end
            else
            begin
                kind_reg <= KIND_SYS;
                type_reg <= in_sb;
                chan_reg <= '0;
            end
        end
        if ((state_reg == ST_CLK) && last_slot)
        begin
            kind_reg <= KIND_TEMPO;
            type_reg <= SB_CLOCK;
            chan_reg <= '0;
            sum_reg  <= sum_calc;
            zero_reg <= sum_zero;
        end
        if (out_load)
        begin
            m_tdata_reg <= {3'd0, zero_reg, sum_reg, tempo_held_reg, t_reg,
                            chan_reg, type_reg};
            m_tuser_reg <= kind_reg;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ===== sv/mctm_checker.sv =====
`default_nettype none

module mctm_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [mctm_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input wire logic [mctm_pkg::KIND_W-1:0]        m_tuser
);
    import mctm_pkg::*;

    // hold a stalled word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_report_no_sum: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_CHAN || m_tuser == KIND_SYS)
        |-> m_tdata[91:60] == '0 && !m_tdata[92])
        else $error("message report carries a beat sum");

    a_tempo_tag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_TEMPO
        |-> m_tdata[7:0] == SB_CLOCK && m_tdata[11:8] == '0)
        else $error("tempo report with wrong type or channel");

    a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_TEMPO && m_tdata[92]
        |-> m_tdata[91:60] == '0 && m_tdata[59:28] == TEMPO_SAT)
        else $error("zero beat sum without saturated tempo");

endmodule

bind midi_clock_tempo_meter_unit mctm_checker u_mctm_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;

    import mctm_pkg::*;

    localparam int BEAT_TICKS    = CLOCKS_PER_BEAT_DEF;
    localparam int QPM_SCALE     = 60 * 256;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] msg_type;
        logic [CHAN_W-1:0] chan;
        logic [TIME_W-1:0] ev_time;
        logic [WORD_W-1:0] tempo;
        logic [WORD_W-1:0] beat_sum;
        logic              zero_sum;
    } tempo_report_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   cfg_we = 1'b0;
    logic [RATE_W-1:0]      cfg_wdata = '0;

    tempo_report_t pending_reports[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    bit            tx_idle = 1'b1;
    bit            rx_idle = 1'b1;
    bit            hold_req = 1'b0;

    // predicted meter state
    logic [RATE_W-1:0] sr_setting = RATE_RESET;
    logic [TIME_W-1:0] last_tick_frame = '0;
    logic              tick_in_period = 1'b0;
    logic [WORD_W-1:0] carried_frames = '0;
    logic              transport_on = 1'b0;
    logic [WORD_W-1:0] tick_gaps [BEAT_TICKS];
    int                tick_slot = 0;
    logic [WORD_W-1:0] held_tempo = TEMPO_RESET;

    midi_clock_tempo_meter_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL midi_clock_tempo_meter_unit");
            $finish;
        end
    end

    task automatic predict_report(input logic mode, input logic [BYTE_W-1:0] sb,
                                  input logic [TIME_W-1:0] ft, input logic [TIME_W-1:0] pf);
        tempo_report_t     r;
        logic [WORD_W-1:0] gap;
        logic [WORD_W-1:0] total;
        logic [63:0]       quo;
        r = '0;
        r.ev_time = ft;
        r.tempo = held_tempo;
        if (mode == MODE_PERIOD)
        begin
            if (transport_on)
                carried_frames = tick_in_period ? WORD_W'(pf) : carried_frames + WORD_W'(pf);
            tick_in_period = 1'b0;
        end
        else if ((sb & SB_SYS_MASK) != SB_SYS_MASK)
        begin
            r.kind = KIND_CHAN;
            r.msg_type = sb & SB_SYS_MASK;
            r.chan = CHAN_W'(sb & SB_CHAN_MASK);
            pending_reports.push_back(r);
        end
        else if (sb == SB_CLOCK)
        begin
            gap = WORD_W'(ft) - WORD_W'(last_tick_frame);
            if (!tick_in_period)
                gap = gap + carried_frames;
            tick_gaps[tick_slot] = gap;
            tick_in_period = 1'b1;
            last_tick_frame = ft;
            tick_slot++;
            if (tick_slot >= BEAT_TICKS)
            begin
                total = '0;
                foreach (tick_gaps[k])
                    total += tick_gaps[k];
                if (total == '0)
                begin
                    held_tempo = TEMPO_SAT;
                    r.zero_sum = 1'b1;
                end
                else
                begin
                    quo = (64'(sr_setting) * 64'(QPM_SCALE)) / 64'(total);
                    held_tempo = (quo > 64'hFFFF_FFFF) ? TEMPO_SAT : quo[WORD_W-1:0];
                end
                tick_slot = 0;
                r.kind = KIND_TEMPO;
                r.msg_type = SB_CLOCK;
                r.tempo = held_tempo;
                r.beat_sum = total;
                pending_reports.push_back(r);
            end
        end
        else if (sb == SB_START)
        begin
            transport_on = 1'b1;
            tick_in_period = 1'b1;
            tick_slot = 0;
            last_tick_frame = ft;
        end
        else if (sb == SB_STOP)
        begin
            transport_on = 1'b0;
        end
        else
        begin
            r.kind = KIND_SYS;
            r.msg_type = sb;
            pending_reports.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (mismatch_count < 100)
            $display("[%0t] mismatch %s: expected %0h, got %0h", $time, what, want, got);
        mismatch_count++;
    endtask

    // output side: random stall per word while rx_idle is set, plus a long hold-off on request
    always @(posedge clk)
    begin : drive_ready
        int unsigned rx_wait;
        int unsigned hold_left;
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (m_tvalid && m_tready)
            rx_wait = rx_idle ? $urandom_range(0, 3) : 0;
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (rx_wait != 0)
        begin
            rx_wait--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_reports
        tempo_report_t want;
        tempo_report_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = m_tuser;
            got.msg_type = m_tdata[7:0];
            got.chan = m_tdata[11:8];
            got.ev_time = m_tdata[27:12];
            got.tempo = m_tdata[59:28];
            got.beat_sum = m_tdata[91:60];
            got.zero_sum = m_tdata[92];
            if (pending_reports.size() == 0)
                report_mismatch("report with none pending, kind", '0, 64'(got.kind));
            else
            begin
                want = pending_reports.pop_front();
                if (got.kind != want.kind)
                    report_mismatch("report_kind", 64'(want.kind), 64'(got.kind));
                if (got.msg_type != want.msg_type)
                    report_mismatch("message_type", 64'(want.msg_type), 64'(got.msg_type));
                if (got.chan != want.chan)
                    report_mismatch("channel", 64'(want.chan), 64'(got.chan));
                if (got.ev_time != want.ev_time)
                    report_mismatch("event_time", 64'(want.ev_time), 64'(got.ev_time));
                if (got.tempo != want.tempo)
                    report_mismatch("tempo_q8", 64'(want.tempo), 64'(got.tempo));
                if (got.beat_sum != want.beat_sum)
                    report_mismatch("interval_sum", 64'(want.beat_sum), 64'(got.beat_sum));
                if (got.zero_sum != want.zero_sum)
                    report_mismatch("zero_sum", 64'(want.zero_sum), 64'(got.zero_sum));
            end
        end
    end

    task automatic send_word(input logic mode, input logic [BYTE_W-1:0] sb,
                             input logic [TIME_W-1:0] ft, input logic [TIME_W-1:0] pf);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 3) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {pf, ft, sb};
        do
            @(posedge clk);
        while (!s_tready);
        predict_report(mode, sb, ft, pf);
    endtask

    // stop sending, let every pending report out, then let the block go idle
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sample_rate(input logic [RATE_W-1:0] rate);
        drain_reports();
        cfg_we <= 1'b1;
        cfg_wdata <= rate;
        @(posedge clk);
        cfg_we <= 1'b0;
        sr_setting = rate;
    endtask

    task automatic test_directed_cases();
        int k;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_word(MODE_EVENT, 8'h80, 16'hFFFF, 16'h0000);
        send_word(MODE_EVENT, 8'h00, 16'h0000, 16'hFFFF);
        send_word(MODE_EVENT, 8'h7F, 16'h8000, 16'h5A5A);
        send_word(MODE_EVENT, 8'hF0, 16'h0001, 16'h0000);
        send_word(MODE_EVENT, 8'hFF, 16'h7FFF, 16'h0000);
        send_word(MODE_EVENT, SB_STOP, 16'h0010, 16'h0000);
        send_word(MODE_PERIOD, 8'hFF, 16'hFFFF, 16'hFFFF);
        send_word(MODE_PERIOD, 8'h00, 16'h0000, 16'h0000);
        // a beat of clocks all at one frame sums to zero and saturates the tempo
        for (k = 0; k < BEAT_TICKS; k++)
            send_word(MODE_EVENT, SB_CLOCK, 16'h0000, 16'h0000);
        send_word(MODE_EVENT, 8'h9F, 16'h0000, 16'h0000);
        send_word(MODE_EVENT, SB_START, 16'd100, 16'h0000);
        send_word(MODE_PERIOD, 8'h00, 16'h0000, 16'd1000);
        send_word(MODE_PERIOD, 8'h00, 16'h0000, 16'd500);
    endtask

    // clocks on an audio timeline cut into periods, with messages and noise
    task automatic run_tempo_traffic(input int n_words);
        int sent;
        int pick;
        int period_len;
        int pos;
        int ivl;
        sent = 0;
        period_len = $urandom_range(64, 1024);
        pos = 0;
        while (sent < n_words)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                ivl = $urandom_range(0, 3 * period_len);
                pos += ivl;
                while (pos >= period_len)
                begin
                    pos -= period_len;
                    send_word(MODE_PERIOD, BYTE_W'($urandom), TIME_W'($urandom),
                              TIME_W'(period_len));
                    sent++;
                end
                send_word(MODE_EVENT, SB_CLOCK, TIME_W'(pos), TIME_W'($urandom));
                sent++;
            end
            else if (pick == 70)
            begin
                send_word(MODE_EVENT, SB_START, TIME_W'(pos), TIME_W'($urandom));
                sent++;
            end
            else if (pick == 71)
            begin
                send_word(MODE_EVENT, SB_STOP, TIME_W'(pos), TIME_W'($urandom));
                sent++;
            end
            else if (pick < 86)
            begin
                send_word(MODE_EVENT, BYTE_W'($urandom),
                          TIME_W'($urandom_range(0, period_len - 1)), TIME_W'($urandom));
                sent++;
            end
            else if (pick < 88)
            begin
                period_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535)
                                                         : $urandom_range(16, 2048);
                pos = pos % period_len;
            end
            else if (pick == 88)
                drain_reports();
            else
            begin
                send_word(1'($urandom), BYTE_W'($urandom), TIME_W'($urandom),
                          TIME_W'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_tempo_sweep();
        logic [RATE_W-1:0] rates [6];
        int k;
        rates[0] = RATE_RESET;
        rates[1] = RATE_W'(8000);
        rates[2] = RATE_W'(192000);
        rates[3] = '0;
        rates[4] = '1;
        rates[5] = RATE_W'($urandom_range(8000, 192000));
        for (k = 0; k < 6; k++)
        begin
            write_sample_rate(rates[k]);
            tx_idle = (k % 3) != 1;
            rx_idle = (k % 4) != 1 && k != 2;
            run_tempo_traffic(190);
        end
    endtask

    // hold the output off so reports pile up and the input stalls
    task automatic test_output_backpressure();
        int k;
        drain_reports();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_req = 1'b1;
        for (k = 0; k < 24; k++)
        begin
            if (k % 3 == 2)
                send_word(MODE_EVENT, SB_CLOCK, TIME_W'(k * 40), TIME_W'($urandom));
            else
                send_word(MODE_EVENT, BYTE_W'($urandom_range(8'h80, 8'hFF)), TIME_W'(k),
                          TIME_W'($urandom));
        end
        drain_reports();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_output_backpressure();
        test_tempo_sweep();
        test_output_backpressure();
        drain_reports();
        if (mismatch_count == 0)
            $display("PASS midi_clock_tempo_meter_unit");
        else
            $display("FAIL midi_clock_tempo_meter_unit");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/mctm_pkg.sv
sv/mctm_div.sv
sv/midi_clock_tempo_meter_unit.sv
sv/mctm_checker.sv
tb/sv/testbench.sv
